FILE: hw/rtl/bm25_pkg.sv
// shared widths, constants and control structs for the bm25 score accumulator
package bm25_pkg;

	localparam int IDW   = 12;
	localparam int TFW   = 16;
	localparam int DLW   = 24;
	localparam int NW    = 13;
	localparam int TW    = 32;
	localparam int SW    = 32;
	localparam int CFG_IW = 1;

	localparam int NUMW  = TFW + TW;
	localparam int DLNW  = DLW + NW;
	localparam int DENW  = NUMW + 1;
	localparam int TFNW  = 17;
	localparam int QW    = 16;

	localparam int LOG_XW = NW + 2;
	localparam int LOG_EW = 4;
	localparam int LOG_FW = 16;
	localparam int LOG_RW = LOG_EW + LOG_FW;
	localparam int LOG_MW = 31;

	localparam int IDFW   = LOG_RW;
	localparam int SCOREW = TFNW + IDFW - 16;

	localparam int MAX_DOCS_DEF = 4096;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic [CFG_IW-1:0] CFG_DOC_COUNT    = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_TOTAL_LENGTH = 1'd1;

	typedef struct packed {
		logic              start;
		logic [LOG_XW-1:0] x;
	} log_req_t;

	typedef struct packed {
		logic              start;
		logic [NUMW-1:0]   num;
		logic [DENW-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic [LOG_RW-1:0] res;
	} log_stat_t;

	typedef struct packed {
		logic              busy;
		logic [TFNW-1:0]   res;
	} div_stat_t;

endpackage

FILE: hw/rtl/bm25_if.sv
// valid/ready channel interfaces for postings and scores
interface bm25_post_if import bm25_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [IDW-1:0] doc_id;
	logic [TFW-1:0] term_freq;
	logic [DLW-1:0] doc_length;
	logic [NW-1:0]  doc_freq;

	modport source (output valid, doc_id, term_freq, doc_length, doc_freq, input ready);
	modport sink   (input valid, doc_id, term_freq, doc_length, doc_freq, output ready);
endinterface

interface bm25_score_if import bm25_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [IDW-1:0] out_doc_id;
	logic [SW-1:0]  new_score;

	modport source (output valid, out_doc_id, new_score, input ready);
	modport sink   (input valid, out_doc_id, new_score, output ready);
endinterface

FILE: hw/rtl/bm25_log2_unit.sv
// iterative log2 in q4.16, one squaring of the mantissa per cycle
module bm25_log2_unit import bm25_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  log_req_t  req,
	output log_stat_t stat
);

	logic              busy_q;
	logic [3:0]        cnt_q;
	logic [LOG_MW-1:0] m_q;
	logic [LOG_EW-1:0] e_q;
	logic [LOG_FW-1:0] frac_q;

	logic [LOG_EW-1:0] e_init;
	logic [4:0]        shamt;
	logic [LOG_MW-1:0] m_init;
	logic [61:0]       sq;
	logic [31:0]       t;

	// highest set bit, zero input counts as one
	always_comb begin
		e_init = '0;
		for (int i = 0; i < LOG_XW; i++) begin
			if (req.x[i]) e_init = LOG_EW'(i);
		end
		shamt  = 5'(LOG_MW - 1) - 5'(e_init);
		m_init = LOG_MW'(req.x) << shamt;
		if (req.x == '0) m_init = LOG_MW'(1) << (LOG_MW - 1);
	end

	assign sq = 62'(m_q) * 62'(m_q);
	assign t  = sq[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			m_q    <= m_init;
			e_q    <= e_init;
			frac_q <= '0;
		end else if (busy_q) begin
			frac_q <= {frac_q[LOG_FW-2:0], t[31]};
			m_q    <= t[31] ? t[31:1] : t[30:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.res  = {e_q, frac_q};

endmodule

FILE: hw/rtl/bm25_div_unit.sv
// restoring divider for the normalized term frequency, one quotient bit per cycle
module bm25_div_unit import bm25_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat
);

	logic            busy_q;
	logic [3:0]      cnt_q;
	logic [DENW:0]   r_q;
	logic [DENW-1:0] den_q;
	logic [QW-1:0]   q_q;
	logic            ge_q;
	logic [TFNW-1:0] res_q;

	logic [DENW:0]   r_sh;
	logic            fits;
	logic            ge_now;
	logic [QW-1:0]   q_next;

	assign r_sh   = {r_q[DENW-1:0], 1'b0};
	assign fits   = r_sh >= {1'b0, den_q};
	assign ge_now = r_q >= {1'b0, den_q};
	assign q_next = {q_q[QW-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= (DENW+1)'(req.num);
			den_q <= req.den;
			q_q   <= '0;
		end else if (busy_q) begin
			// first step still sees the plain numerator
			if (cnt_q == 4'd0) ge_q <= ge_now;
			r_q <= fits ? r_sh - {1'b0, den_q} : r_sh;
			q_q <= q_next;
			if (cnt_q == 4'd15) begin
				if (den_q == '0) res_q <= '0;
				else if (ge_q) res_q <= TFNW'(1) << QW;
				else res_q <= {1'b0, q_next};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.res  = res_q;

endmodule

FILE: hw/rtl/bm25_score_mem.sv
// per-document score memory with a clearing sweep after reset
module bm25_score_mem import bm25_pkg::*; #(
	parameter int DEPTH = MAX_DOCS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [SW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [SW-1:0] wr_data,
	output logic          cleared
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [SW-1:0] mem [DEPTH];
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic [SW-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST) clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) mem[clr_addr_q] <= '0;
		else if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
	assign cleared = !clearing_q;

endmodule

FILE: hw/rtl/bm25_score_accumulator.sv
// bm25 term scoring with saturating per-document accumulation
// one posting at a time: a new posting is accepted only after the previous one has left ST_ACC
// the two 16-step passes of the shared log2 squarer dominate the time per posting; the divider runs alongside
// a finished score waits in the output register while the next posting is taken
// reset: doc_count 1, total_length 0; then a sweep clears every table entry, posting ready low
module bm25_score_accumulator import bm25_pkg::*; #(
	parameter int MAX_DOCS = MAX_DOCS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	bm25_post_if.sink         post,
	bm25_score_if.source      result,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [TW-1:0]     cfg_wdata
);

	localparam int AW = $clog2(MAX_DOCS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_DIVST, ST_LOGA, ST_LOGB, ST_IDF, ST_SCR, ST_ACC
	} state_t;

	state_t state_q;

	logic [NW-1:0]     n_q;
	logic [TW-1:0]     t_q;
	logic [IDW-1:0]    id_q;
	logic [TFW-1:0]    tf_q;
	logic [DLW-1:0]    dl_q;
	logic [NW-1:0]     df_q;
	logic [NUMW-1:0]   num_q;
	logic [DLNW-1:0]   dln_q;
	logic [LOG_RW-1:0] la_q;
	logic [LOG_RW-1:0] d_q;
	logic [IDFW-1:0]   idf_q;
	logic [SCOREW-1:0] score_q;
	logic              res_valid_q;
	logic [IDW-1:0]    res_id_q;
	logic [SW-1:0]     res_score_q;

	logic [NW-1:0]     n_eff;
	logic [NW-1:0]     df_clamped;
	log_req_t          log_req;
	log_stat_t         log_stat;
	div_req_t          div_req;
	div_stat_t         div_stat;
	logic              clr_done;
	logic [SW-1:0]     mem_rd;
	logic              in_fire;
	logic              acc_go;
	logic              in_range;
	logic [SW:0]       sum;
	logic [SW-1:0]     sat;
	logic [51:0]       idf_prod;
	logic [TFNW+IDFW-1:0] score_prod;

	assign n_eff      = (n_q == '0) ? NW'(1) : n_q;
	assign df_clamped = (post.doc_freq > n_eff) ? n_eff : post.doc_freq;
	assign post.ready = (state_q == ST_IDLE) && clr_done;
	assign in_fire    = post.valid && post.ready;
	assign acc_go     = (state_q == ST_ACC) && (!res_valid_q || result.ready);
	assign in_range   = int'(id_q) < MAX_DOCS;

	assign sum = {1'b0, mem_rd} + (SW+1)'(score_q);
	assign sat = sum[SW] ? '1 : sum[SW-1:0];

	assign idf_prod   = 52'(d_q) * 52'(LN2_Q32);
	assign score_prod = (TFNW+IDFW)'(div_stat.res) * (TFNW+IDFW)'(idf_q);

	always_comb begin
		log_req.start = (state_q == ST_PREP) || (state_q == ST_LOGA && !log_stat.busy);
		log_req.x     = (state_q == ST_PREP) ? {1'b0, n_eff, 1'b0} + LOG_XW'(2)
		                                     : {1'b0, df_q, 1'b1};
		div_req.start = (state_q == ST_DIVST);
		div_req.num   = num_q;
		div_req.den   = {1'b0, num_q} + DENW'(dln_q);
	end

	bm25_log2_unit u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req),
		.stat   (log_stat)
	);

	bm25_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	bm25_score_mem #(
		.DEPTH (MAX_DOCS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (AW'(post.doc_id)),
		.rd_data (mem_rd),
		.wr_en   (acc_go && in_range),
		.wr_addr (AW'(id_q)),
		.wr_data (sat),
		.cleared (clr_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(1);
			t_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DOC_COUNT:    n_q <= cfg_wdata[NW-1:0];
				CFG_TOTAL_LENGTH: t_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (acc_go) res_valid_q <= 1'b1;
			else if (result.valid && result.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_PREP;
				end
				ST_PREP:  state_q <= ST_DIVST;
				ST_DIVST: state_q <= ST_LOGA;
				ST_LOGA: begin
					if (!log_stat.busy) state_q <= ST_LOGB;
				end
				ST_LOGB: begin
					if (!log_stat.busy && !div_stat.busy) state_q <= ST_IDF;
				end
				ST_IDF: state_q <= ST_SCR;
				ST_SCR: state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			id_q <= post.doc_id;
			tf_q <= post.term_freq;
			dl_q <= post.doc_length;
			df_q <= df_clamped;
		end
		if (state_q == ST_PREP) begin
			num_q <= NUMW'(tf_q) * NUMW'(t_q);
			dln_q <= DLNW'(dl_q) * DLNW'(n_eff);
		end
		if (state_q == ST_LOGA && !log_stat.busy) la_q <= log_stat.res;
		if (state_q == ST_LOGB) begin
			d_q <= (la_q > log_stat.res) ? la_q - log_stat.res : '0;
		end
		if (state_q == ST_IDF) idf_q <= idf_prod[51:32];
		if (state_q == ST_SCR) score_q <= score_prod[TFNW+IDFW-1:16];
		if (acc_go) begin
			res_id_q    <= id_q;
			res_score_q <= in_range ? sat : SW'(score_q);
		end
	end

	assign result.valid      = res_valid_q;
	assign result.out_doc_id = res_id_q;
	assign result.new_score  = res_score_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !post.ready)
		else $error("posting taken while another is in flight");

	a_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !log_stat.busy && !div_stat.busy)
		else $error("arithmetic unit busy while idle");

	a_acc_shows: assert property (@(posedge clk) disable iff (!arst_n)
		acc_go |=> result.valid)
		else $error("finished score not presented");

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> state_q == ST_IDLE)
		else $error("posting processed during table clear");

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the bm25 score accumulator
module testbench import bm25_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_GAP   = 45;

	typedef struct {
		logic [IDW-1:0] doc_id;
		logic [SW-1:0]  score;
	} score_rec_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = CFG_DOC_COUNT;
	logic [TW-1:0]       cfg_wdata = '0;

	bm25_post_if  post_ch ();
	bm25_score_if score_ch ();

	bm25_score_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.post      (post_ch),
		.result    (score_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// local copy of block state
	logic [NW-1:0]  n_docs = 1;
	logic [TW-1:0]  len_sum = 0;
	logic [SW-1:0]  doc_scores [MAX_DOCS_DEF];
	score_rec_t     pending_scores [$];

	int  errors = 0;
	int  postings_sent = 0;
	int  scores_seen = 0;
	int  cycles = 0;
	bit  no_gaps = 0;
	bit  hold_req = 0;

	always #6 clk = ~clk;

	initial begin
		post_ch.valid = 1'b0;
		post_ch.doc_id = '0;
		post_ch.term_freq = '0;
		post_ch.doc_length = '0;
		post_ch.doc_freq = '0;
		score_ch.ready = 1'b0;
		foreach (doc_scores[i]) doc_scores[i] = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d scores still pending", $realtime, pending_scores.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] log2_fixed(logic [63:0] x);
		logic [63:0] m;
		logic [63:0] frac;
		int e;
		frac = 0;
		e = 0;
		if (x == 0) x = 1;
		while (e < 31 && (x >> (e + 1)) != 0) e++;
		m = x << (30 - e);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (64'(e) << 16) | frac;
	endfunction

	// term score in q16.16 for the current collection settings
	function automatic logic [63:0] term_score(logic [TFW-1:0] tf, logic [DLW-1:0] dl,
			logic [NW-1:0] df_in);
		logic [63:0] n, df, num, den, tfn, rem, la, lb, d, idf;
		n = (n_docs == 0) ? 64'd1 : 64'(n_docs);
		df = (64'(df_in) > n) ? n : 64'(df_in);
		num = 64'(tf) * 64'(len_sum);
		den = num + 64'(dl) * n;
		if (den == 0) tfn = 0;
		else if (num >= den) tfn = 65536;
		else begin
			rem = num;
			tfn = 0;
			for (int i = 0; i < 16; i++) begin
				rem = rem << 1;
				tfn = tfn << 1;
				if (rem >= den) begin
					rem = rem - den;
					tfn = tfn | 1;
				end
			end
		end
		la = log2_fixed(2 * n + 2);
		lb = log2_fixed(2 * df + 1);
		d = (la > lb) ? la - lb : 0;
		idf = (d * 64'(LN2_Q32)) >> 32;
		return (tfn * idf) >> 16;
	endfunction

	function automatic void accumulate(logic [IDW-1:0] id, logic [TFW-1:0] tf,
			logic [DLW-1:0] dl, logic [NW-1:0] df);
		logic [63:0] acc;
		score_rec_t rec;
		acc = 64'(doc_scores[id]) + term_score(tf, dl, df);
		if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
		doc_scores[id] = acc[31:0];
		rec.doc_id = id;
		rec.score = acc[31:0];
		pending_scores.insert(pending_scores.size(), rec);
	endfunction

	// result checker
	always @(posedge clk) begin
		score_rec_t want;
		if (arst_n && score_ch.valid && score_ch.ready) begin
			scores_seen++;
			if (pending_scores.size() == 0) begin
				errors++;
				$display("%0t unexpected score: expected none, actual id %0d score %h",
					$realtime, score_ch.out_doc_id, score_ch.new_score);
			end else begin
				want = pending_scores.pop_front();
				if (score_ch.out_doc_id !== want.doc_id) begin
					errors++;
					$display("%0t out_doc_id mismatch: expected %0d, actual %0d",
						$realtime, want.doc_id, score_ch.out_doc_id);
				end
				if (score_ch.new_score !== want.score) begin
					errors++;
					$display("%0t new_score mismatch (id %0d): expected %h, actual %h",
						$realtime, want.doc_id, want.score, score_ch.new_score);
				end
			end
		end
	end

	// score receiver with random stalls and an occasional long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				score_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 0;
			end
			w = no_gaps ? 0 : $urandom_range(0, 4);
			if (w > 0) begin
				@(negedge clk);
				score_ch.ready <= 1'b0;
				repeat (w - 1) @(negedge clk);
			end
			@(negedge clk);
			score_ch.ready <= 1'b1;
			do @(posedge clk); while (!(score_ch.valid && score_ch.ready) && !hold_req);
		end
	end

	task automatic send_posting(logic [IDW-1:0] id, logic [TFW-1:0] tf, logic [DLW-1:0] dl,
			logic [NW-1:0] df);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			post_ch.valid <= 1'b0;
		end
		@(negedge clk);
		post_ch.valid <= 1'b1;
		post_ch.doc_id <= id;
		post_ch.term_freq <= tf;
		post_ch.doc_length <= dl;
		post_ch.doc_freq <= df;
		do @(posedge clk); while (!post_ch.ready);
		accumulate(id, tf, dl, df);
		postings_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		post_ch.valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [TW-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == CFG_DOC_COUNT) n_docs = value[NW-1:0];
		else len_sum = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_collection(logic [NW-1:0] n, logic [TW-1:0] t);
		wait_drained();
		write_reg(CFG_DOC_COUNT, TW'(n));
		write_reg(CFG_TOTAL_LENGTH, t);
	endtask

	function automatic logic [DLW-1:0] rand_length();
		int w;
		w = $urandom_range(1, DLW);
		return DLW'($urandom) & DLW'((64'd1 << w) - 1);
	endfunction

	task automatic random_posting(int hot_ids);
		logic [IDW-1:0] id;
		logic [TFW-1:0] tf;
		logic [NW-1:0] df;
		id = ($urandom_range(0, 3) == 0) ? IDW'($urandom) : IDW'($urandom_range(0, hot_ids));
		case ($urandom_range(0, 9))
			0: tf = 0;
			1: tf = TFW'($urandom);
			default: tf = TFW'($urandom_range(1, 40));
		endcase
		df = ($urandom_range(0, 4) == 0) ? NW'($urandom) : NW'($urandom_range(1, 4096));
		send_posting(id, tf, rand_length(), df);
	endtask

	// reset values first, then the corner cases of every field
	task automatic test_directed();
		send_posting(0, 1, 0, 1);
		send_posting(12'hFFF, 16'hFFFF, 24'hFF_FFFF, 13'h1FFF);
		set_collection(0, 32'd1000);
		send_posting(1, 3, 20, 1);
		send_posting(1, 3, 20, 13'd4096);
		set_collection(13'd4096, 32'd409600);
		send_posting(2, 0, 100, 5);
		send_posting(3, 16'hFFFF, 0, 1);
		send_posting(3, 1, 24'hFF_FFFF, 1);
		send_posting(4, 5, 100, 13'd4096);
		send_posting(4, 5, 100, 13'h1FFF);
		send_posting(12'hFFF, 16'hFFFF, 24'hFF_FFFF, 1);
		set_collection(13'h1FFF, 32'hFFFF_FFFF);
		send_posting(5, 16'hFFFF, 1, 1);
		send_posting(5, 16'hFFFF, 24'hFF_FFFF, 13'h1000);
		send_posting(0, 1, 24'hFF_FFFF, 13'h1FFF);
		set_collection(13'd10, 32'd0);
		send_posting(6, 7, 50, 2);
		send_posting(6, 7, 0, 2);
		send_posting(6, 0, 0, 2);
		send_posting(7, 16'hAAAA, 24'h55_5555, 13'h0AAA);
		send_posting(7, 16'h5555, 24'hAA_AAAA, 13'h1555);
	endtask

	// the receiver stalls for a long stretch while postings keep coming
	task automatic test_backpressure();
		set_collection(13'd200, 32'd20000);
		hold_req = 1;
		repeat (12) random_posting(15);
		wait_drained();
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			case (p % 4)
				0: set_collection(NW'($urandom_range(1, 4096)), $urandom_range(0, 1 << 20));
				1: set_collection(NW'($urandom), $urandom);
				2: set_collection(NW'($urandom_range(1, 64)), $urandom_range(0, 5000));
				default: set_collection(13'd4096, 32'hFFFF_FFFF);
			endcase
			no_gaps = (p % 3 == 2);
			for (int i = 0; i < per_phase; i++) random_posting((p % 2) ? 7 : 255);
			no_gaps = 0;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(10, 122);
		wait_drained();
		$display("run covered %0d postings and %0d scores across directed, stall and random phases",
			postings_sent, scores_seen);
		if (errors == 0 && pending_scores.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d scores missing", errors, pending_scores.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
